@@ sv/json_key_value_extract_macros.svh @@
`ifndef JSON_KEY_VALUE_EXTRACT_MACROS_SVH
`define JSON_KEY_VALUE_EXTRACT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define JKV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define JKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/jkv_pkg.sv @@
`default_nettype none
package jkv_pkg;

  localparam int KEY_MAX_BYTES = 16;
  localparam int WIN_DEPTH     = KEY_MAX_BYTES + 2;
  localparam int KLEN_W        = $clog2(KEY_MAX_BYTES + 2);
  localparam int KIDX_W        = $clog2(KEY_MAX_BYTES);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI  = 2'd2;

  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_R        = 8'h72;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_COLON,
    PH_SKIPWS,
    PH_QUOTED,
    PH_BARE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       value_end;
    logic       found;
  } out_beat_t;

  typedef struct packed {
    logic [KLEN_W-1:0]                 len;
    logic [KEY_MAX_BYTES-1:0][7:0]     bytes;
  } key_cfg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

endpackage
`default_nettype wire

@@ sv/jkv_cfg.sv @@
`default_nettype none
module jkv_cfg
  import jkv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output key_cfg_t                   key_cfg
);

  logic [4:0]            key_len_r;
  logic [CFG_DATA_W-1:0] key_lo_r;
  logic [CFG_DATA_W-1:0] key_hi_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= 5'd1;
      key_lo_r  <= '0;
      key_hi_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_LEN: key_len_r <= cfg_data[4:0];
        CFG_KEY_LO:  key_lo_r  <= cfg_data;
        CFG_KEY_HI:  key_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // lengths above the window capacity clamp to the maximum
  always_comb begin
    if (key_len_r > 5'(KEY_MAX_BYTES)) begin
      key_cfg.len = KLEN_W'(KEY_MAX_BYTES);
    end else begin
      key_cfg.len = KLEN_W'(key_len_r);
    end
    key_cfg.bytes = {key_hi_r, key_lo_r};
  end

endmodule
`default_nettype wire

@@ sv/jkv_window.sv @@
`default_nettype none
module jkv_window
  import jkv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire win_ctl_t   ctl,
  input  wire logic [7:0] data_byte,
  input  wire key_cfg_t   key_cfg,
  output logic            match
);

  logic [WIN_DEPTH-1:0][7:0] window_r;
  logic [WIN_DEPTH-1:0][7:0] window_nxt;
  logic [WIN_DEPTH-1:0][7:0] shifted;

  assign shifted = {window_r[WIN_DEPTH-2:0], data_byte};

  // newest byte sits at position 0; quoted key reads backwards from there
  always_comb begin
    logic [KLEN_W-1:0] diff;
    match = (shifted[0] == CH_QUOTE);
    diff  = '0;
    for (int j = 1; j < WIN_DEPTH; j++) begin
      diff = key_cfg.len - KLEN_W'(j);
      if (KLEN_W'(j) == key_cfg.len + KLEN_W'(1)) begin
        match = match && (shifted[j] == CH_QUOTE);
      end else if (KLEN_W'(j) <= key_cfg.len) begin
        match = match && (shifted[j] == key_cfg.bytes[diff[KIDX_W-1:0]]);
      end
    end
  end

  always_comb begin
    window_nxt = window_r;
    if (ctl.clear) begin
      window_nxt = '0;
    end else if (ctl.shift) begin
      window_nxt = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else begin
      window_r <= window_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/jkv_fsm.sv @@
`default_nettype none
module jkv_fsm
  import jkv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_beat_t in_beat,
  input  wire logic     match,
  output win_ctl_t      win_ctl,
  output logic          res_valid,
  output out_beat_t     res
);

  phase_t phase_r, phase_nxt;
  logic   esc_r, esc_nxt;
  logic   is_term;
  logic   [7:0] c;
  logic   [7:0] decoded;
  logic   last;

  assign c    = in_beat.data_byte;
  assign last = in_beat.frame_last;

  assign is_term = (c == CH_COMMA) || (c == CH_RBRACE) || (c == CH_RBRACKET);

  always_comb begin
    unique case (c)
      CH_N:    decoded = CH_LF;
      CH_T:    decoded = CH_TAB;
      CH_R:    decoded = CH_CR;
      default: decoded = c;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    esc_nxt       = esc_r;
    res_valid     = 1'b0;
    res           = '0;
    win_ctl.shift = accept && (phase_r == PH_SEARCH);
    win_ctl.clear = accept && last;
    if (accept) begin
      unique case (phase_r)
        PH_SEARCH: begin
          if (match) phase_nxt = PH_COLON;
          if (last) begin
            res_valid     = 1'b1;
            res.value_end = 1'b1;
          end
        end
        PH_COLON: begin
          if (c == CH_COLON) phase_nxt = PH_SKIPWS;
          if (last) begin
            res_valid     = 1'b1;
            res.value_end = 1'b1;
          end
        end
        PH_SKIPWS: begin
          if ((c == CH_SPACE) || (c == CH_TAB)) begin
            if (last) begin
              res_valid     = 1'b1;
              res.value_end = 1'b1;
            end
          end else if (c == CH_QUOTE) begin
            phase_nxt = PH_QUOTED;
            esc_nxt   = 1'b0;
            if (last) begin
              res_valid     = 1'b1;
              res.value_end = 1'b1;
              res.found     = 1'b1;
            end
          end else if (is_term) begin
            phase_nxt     = PH_DONE;
            res_valid     = 1'b1;
            res.value_end = 1'b1;
            res.found     = 1'b1;
          end else begin
            phase_nxt      = PH_BARE;
            res_valid      = 1'b1;
            res.value_byte = c;
            res.byte_valid = 1'b1;
            res.value_end  = last;
            res.found      = 1'b1;
          end
        end
        PH_QUOTED: begin
          if (esc_r) begin
            esc_nxt        = 1'b0;
            res_valid      = 1'b1;
            res.value_byte = decoded;
            res.byte_valid = 1'b1;
            res.value_end  = last;
            res.found      = 1'b1;
          end else if (c == CH_QUOTE) begin
            phase_nxt     = PH_DONE;
            res_valid     = 1'b1;
            res.value_end = 1'b1;
            res.found     = 1'b1;
          end else if (c == CH_BSLASH) begin
            if (last) begin
              res_valid      = 1'b1;
              res.value_byte = c;
              res.byte_valid = 1'b1;
              res.value_end  = 1'b1;
              res.found      = 1'b1;
            end else begin
              esc_nxt = 1'b1;
            end
          end else begin
            res_valid      = 1'b1;
            res.value_byte = c;
            res.byte_valid = 1'b1;
            res.value_end  = last;
            res.found      = 1'b1;
          end
        end
        PH_BARE: begin
          if (is_term || (c == CH_SPACE)) begin
            phase_nxt     = PH_DONE;
            res_valid     = 1'b1;
            res.value_end = 1'b1;
            res.found     = 1'b1;
          end else begin
            res_valid      = 1'b1;
            res.value_byte = c;
            res.byte_valid = 1'b1;
            res.value_end  = last;
            res.found      = 1'b1;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
      if (last) begin
        phase_nxt = PH_SEARCH;
        esc_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      esc_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/jkv_outbuf.sv @@
`default_nettype none
module jkv_outbuf
  import jkv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_valid,
  input  wire out_beat_t res,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_beat_t skid_data_r, skid_data_nxt;
  logic      load_ok;

  assign load_ok   = !out_valid_r || !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid holds a beat that arrived while the output was stalled
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (load_ok) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (load_ok) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (load_ok) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
`default_nettype wire

@@ sv/json_key_value_extract.sv @@
// The result of an accepted input beat is registered before it shows on out_valid.
// Throughput: one input beat per cycle while in_stall is low; the quoted-key window
// compare and the phase logic sit between the input port and the output register.
// A two-deep output stage (register plus skid) stalls input only when both are full.
// Reset (rst_n low, synchronous): search phase, window cleared, outputs empty,
// key length 1 and key bytes zero.
`default_nettype none
module json_key_value_extract
  import jkv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_beat_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  key_cfg_t  key_cfg;
  win_ctl_t  win_ctl;
  logic      accept;
  logic      match;
  logic      res_valid;
  out_beat_t res;

  assign accept = in_valid && !in_stall;

  jkv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_cfg   (key_cfg)
  );

  jkv_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl),
    .data_byte (in_data.data_byte),
    .key_cfg   (key_cfg),
    .match     (match)
  );

  jkv_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_beat   (in_data),
    .match     (match),
    .win_ctl   (win_ctl),
    .res_valid (res_valid),
    .res       (res)
  );

  jkv_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ sv/jkv_checker.sv @@
`default_nettype none
`include "json_key_value_extract_macros.svh"
module jkv_checker
  import jkv_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire in_beat_t              in_data,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire out_beat_t             out_data,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  `JKV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
  `JKV_ASSERT_NOW(a_stall_full, in_stall, out_valid, "input stalled with output empty")
  `JKV_ASSERT_NOW(a_notfound_end, out_valid && !out_data.found, out_data.value_end && !out_data.byte_valid, "failed search beat malformed")
  `JKV_ASSERT_NOW(a_nobyte_end, out_valid && !out_data.byte_valid, out_data.value_end && (out_data.value_byte == 8'h00), "byteless beat not an end beat")

endmodule

bind json_key_value_extract jkv_checker u_jkv_checker (.*);
`default_nettype wire
